@@ design/spq_pkg.sv @@
// Package for the sorted priority queue: field widths, request and status codes,
// and the request and result transfer structs. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int TAG_BITS_DEF   = 16;
    localparam int PRIO_BITS      = 10;
    localparam int TAG_FIELD_BITS = 16;
    localparam int POS_BITS       = 6;
    localparam int COUNT_BITS     = 7;
    localparam int REQ_BITS       = 3;

    localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_FIND   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_WR,
        S_POP_HEAD,
        S_POP_SH,
        S_FIND,
        S_RD_WAIT
    } state_t;

    typedef struct packed {
        logic [REQ_BITS-1:0]       req_type;
        logic [TAG_FIELD_BITS-1:0] tag;
        logic [PRIO_BITS-1:0]      priority_req;
        logic [POS_BITS-1:0]       index;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [TAG_FIELD_BITS-1:0] entry_tag;
        logic [PRIO_BITS-1:0]      entry_priority;
        logic [POS_BITS-1:0]       entry_position;
        logic [COUNT_BITS-1:0]     count;
        logic                      is_empty;
    } rsp_t;

endpackage

`default_nettype wire

@@ design/spq_ram.sv @@
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Sorted minimum-first priority queue held in one RAM, with a sequencer that
// shifts entries one per cycle. Depends on spq_pkg and spq_ram.
//
//   Channel   Signals                 Transfer when
//   request   start, busy, request    rising edge with start high and busy low
//   result    done, result            rising edge that ends the cycle with done high
//
// An insert shifts each held entry at or above the new priority up one place and
// then writes the new entry; a pop returns the head and shifts the rest down; a
// find scans from the head. The RAM's write port and read port move one entry per
// cycle. Reset clears the state, the count and done; the RAM is not cleared.
// Results cannot be stalled; the next request may be transferred in the done cycle.
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire spq_pkg::req_t request,
    output logic               done,
    output spq_pkg::rsp_t      result
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > spq_pkg::POS_BITS) ? CW : spq_pkg::POS_BITS;
    localparam int EW = TAG_BITS + spq_pkg::PRIO_BITS;

    spq_pkg::state_t state_reg, state_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [spq_pkg::PRIO_BITS-1:0] prio_reg, prio_next;
    logic [EW-1:0] hold_reg, hold_next;
    logic done_reg, done_next;
    spq_pkg::rsp_t result_reg, result_next;

    logic ram_we, ram_re;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [TAG_BITS-1:0] rd_tag;
    logic [spq_pkg::PRIO_BITS-1:0] rd_prio;
    logic [TAG_BITS-1:0] in_tag;
    logic [EW-1:0] new_entry;
    logic is_full, is_none, idx_ok, shift_up, ptr_zero, at_last, tag_hit, one_left;

    logic fin;
    spq_pkg::status_t fin_st;
    logic [EW-1:0] fin_entry;
    logic [PW-1:0] fin_pos;

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_tag    = ram_rdata[EW-1:spq_pkg::PRIO_BITS];
    assign rd_prio   = ram_rdata[spq_pkg::PRIO_BITS-1:0];
    assign in_tag    = TAG_BITS'(request.tag);
    assign new_entry = {tag_reg, prio_reg};
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_none   = (count_reg == '0);
    assign idx_ok    = (XW'(request.index) < XW'(count_reg));
    assign shift_up  = (rd_prio >= prio_reg);
    assign ptr_zero  = (ptr_reg == '0);
    assign at_last   = (CW'(ptr_reg) == count_reg - CW'(1));
    assign tag_hit   = (rd_tag == tag_reg);
    assign one_left  = (count_reg == CW'(1));

    assign busy   = (state_reg != spq_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (request.req_type)
                        spq_pkg::REQ_INSERT:
                        begin
                            if (!is_full)
                            begin
                                state_next = is_none ? spq_pkg::S_INS_WR : spq_pkg::S_INS_CHK;
                            end
                        end
                        spq_pkg::REQ_POP:
                        begin
                            if (!is_none)
                            begin
                                state_next = spq_pkg::S_POP_HEAD;
                            end
                        end
                        spq_pkg::REQ_FIND:
                        begin
                            if (!is_none)
                            begin
                                state_next = spq_pkg::S_FIND;
                            end
                        end
                        spq_pkg::REQ_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = spq_pkg::S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = spq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            spq_pkg::S_INS_CHK:
            begin
                if (!shift_up)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
                else if (ptr_zero)
                begin
                    state_next = spq_pkg::S_INS_WR;
                end
            end
            spq_pkg::S_POP_HEAD:
            begin
                state_next = one_left ? spq_pkg::S_IDLE : spq_pkg::S_POP_SH;
            end
            spq_pkg::S_POP_SH:
            begin
                if (at_last)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            spq_pkg::S_FIND:
            begin
                if (tag_hit || at_last)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            spq_pkg::S_INS_WR, spq_pkg::S_RD_WAIT:
            begin
                state_next = spq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        hold_next  = hold_reg;
        fin        = 1'b0;
        fin_st     = spq_pkg::ST_OK;
        fin_entry  = '0;
        fin_pos    = '0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    tag_next  = in_tag;
                    prio_next = request.priority_req;
                    unique case (request.req_type)
                        spq_pkg::REQ_INSERT:
                        begin
                            if (is_full)
                            begin
                                fin    = 1'b1;
                                fin_st = spq_pkg::ST_FULL;
                            end
                            else if (is_none)
                            begin
                                ptr_next = '0;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = PW'(count_reg - CW'(1));
                                ptr_next  = PW'(count_reg - CW'(1));
                            end
                        end
                        spq_pkg::REQ_POP:
                        begin
                            if (is_none)
                            begin
                                fin    = 1'b1;
                                fin_st = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                            end
                        end
                        spq_pkg::REQ_FIND:
                        begin
                            if (is_none)
                            begin
                                fin    = 1'b1;
                                fin_st = spq_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                ptr_next  = '0;
                            end
                        end
                        spq_pkg::REQ_READ:
                        begin
                            if (idx_ok)
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = PW'(request.index);
                                ptr_next  = PW'(request.index);
                            end
                            else
                            begin
                                fin    = 1'b1;
                                fin_st = spq_pkg::ST_NOT_FOUND;
                            end
                        end
                        spq_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            fin        = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            spq_pkg::S_INS_CHK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg + PW'(1);
                if (shift_up)
                begin
                    ram_wdata = ram_rdata;
                    if (!ptr_zero)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg - PW'(1);
                        ptr_next  = ptr_reg - PW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = new_entry;
                    count_next = count_reg + CW'(1);
                    fin        = 1'b1;
                    fin_entry  = new_entry;
                    fin_pos    = ptr_reg + PW'(1);
                end
            end
            spq_pkg::S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = new_entry;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
                fin_entry  = new_entry;
                fin_pos    = ptr_reg;
            end
            spq_pkg::S_POP_HEAD:
            begin
                hold_next = ram_rdata;
                if (one_left)
                begin
                    count_next = '0;
                    fin        = 1'b1;
                    fin_entry  = ram_rdata;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = PW'(1);
                    ptr_next  = PW'(1);
                end
            end
            spq_pkg::S_POP_SH:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - PW'(1);
                ram_wdata = ram_rdata;
                if (at_last)
                begin
                    count_next = count_reg - CW'(1);
                    fin        = 1'b1;
                    fin_entry  = hold_reg;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + PW'(1);
                    ptr_next  = ptr_reg + PW'(1);
                end
            end
            spq_pkg::S_FIND:
            begin
                if (tag_hit)
                begin
                    fin       = 1'b1;
                    fin_entry = ram_rdata;
                    fin_pos   = ptr_reg;
                end
                else if (at_last)
                begin
                    fin    = 1'b1;
                    fin_st = spq_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + PW'(1);
                    ptr_next  = ptr_reg + PW'(1);
                end
            end
            spq_pkg::S_RD_WAIT:
            begin
                fin       = 1'b1;
                fin_entry = ram_rdata;
                fin_pos   = ptr_reg;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        done_next   = fin;
        result_next = result_reg;
        if (fin)
        begin
            result_next.status         = fin_st;
            result_next.entry_tag      =
                spq_pkg::TAG_FIELD_BITS'(fin_entry[EW-1:spq_pkg::PRIO_BITS]);
            result_next.entry_priority = fin_entry[spq_pkg::PRIO_BITS-1:0];
            result_next.entry_position = spq_pkg::POS_BITS'(fin_pos);
            result_next.count          = spq_pkg::COUNT_BITS'(count_next);
            result_next.is_empty       = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        tag_reg    <= tag_next;
        prio_reg   <= prio_next;
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("RAM read and write hit the same entry in one cycle.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == spq_pkg::S_IDLE))
        else $error("Result strobe raised while a request is still in progress.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != spq_pkg::S_IDLE) |=>
            (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1))
            || (count_reg == $past(count_reg) - CW'(1)))
        else $error("Entry count moved by more than one during a request.");

endmodule

`default_nettype wire

@@ bench/sorted_priority_queue_tb.sv @@
// Self-checking testbench for sorted_priority_queue: directed and random request streams,
// each result checked against an in-bench model of the sorted list.
// Depends on spq_pkg and the sorted_priority_queue RTL.

module sorted_priority_queue_tb;

    localparam int QDEPTH        = spq_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 840;
    localparam int IDLE_PCT      = 13;
    localparam int QUIET_FROM    = 300;
    localparam int QUIET_TO      = 560;
    localparam int END_CYCLES    = 2 * QDEPTH + 10;
    localparam int TIMEOUT_UNITS = 5_000_000;

    localparam logic [spq_pkg::REQ_BITS-1:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [spq_pkg::REQ_BITS-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [spq_pkg::REQ_BITS-1:0] REQ_UNUSED_HI  = 3'd7;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_QUERY
    } phase_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    spq_pkg::req_t request = '0;
    logic busy;
    logic done;
    spq_pkg::rsp_t result;

    spq_pkg::req_t pending_items[$];
    spq_pkg::rsp_t expected_results[$];

    logic [spq_pkg::TAG_FIELD_BITS-1:0] held_tags[QDEPTH];
    logic [spq_pkg::PRIO_BITS-1:0]      held_prios[QDEPTH];
    int                                 held_count = 0;

    logic [spq_pkg::TAG_FIELD_BITS-1:0] tag_pool[16];
    int gen_count      = 0;
    int total_items    = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatches     = 0;

    sorted_priority_queue #(
        .DEPTH   (QDEPTH),
        .TAG_BITS(spq_pkg::TAG_BITS_DEF)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic spq_pkg::rsp_t serve_request(spq_pkg::req_t r);
        spq_pkg::rsp_t res;
        int   pos;
        int   i;
        res = '0;
        case (r.req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (held_count >= QDEPTH)
                begin
                    res.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_count && r.priority_req > held_prios[pos])
                        pos++;
                    for (i = held_count; i > pos; i--)
                    begin
                        held_tags[i]  = held_tags[i-1];
                        held_prios[i] = held_prios[i-1];
                    end
                    held_tags[pos]  = r.tag;
                    held_prios[pos] = r.priority_req;
                    held_count++;
                    res.entry_tag      = r.tag;
                    res.entry_priority = r.priority_req;
                    res.entry_position = pos[spq_pkg::POS_BITS-1:0];
                end
            end
            spq_pkg::REQ_POP:
            begin
                if (held_count == 0)
                begin
                    res.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.entry_tag      = held_tags[0];
                    res.entry_priority = held_prios[0];
                    for (i = 1; i < held_count; i++)
                    begin
                        held_tags[i-1]  = held_tags[i];
                        held_prios[i-1] = held_prios[i];
                    end
                    held_count--;
                end
            end
            spq_pkg::REQ_FIND:
            begin
                pos = -1;
                for (i = held_count - 1; i >= 0; i--)
                    if (held_tags[i] == r.tag)
                        pos = i;
                if (pos < 0)
                begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    res.entry_tag      = held_tags[pos];
                    res.entry_priority = held_prios[pos];
                    res.entry_position = pos[spq_pkg::POS_BITS-1:0];
                end
            end
            spq_pkg::REQ_READ:
            begin
                if (int'(r.index) < held_count)
                begin
                    res.entry_tag      = held_tags[r.index];
                    res.entry_priority = held_prios[r.index];
                    res.entry_position = r.index;
                end
                else
                begin
                    res.status = spq_pkg::ST_NOT_FOUND;
                end
            end
            spq_pkg::REQ_CLEAR:
            begin
                held_count = 0;
            end
            default:
            begin
            end
        endcase
        res.count    = held_count[spq_pkg::COUNT_BITS-1:0];
        res.is_empty = (held_count == 0);
        return res;
    endfunction

    function automatic spq_pkg::req_t random_request();
        spq_pkg::req_t r;
        r.req_type     = spq_pkg::REQ_BITS'($urandom_range(7, 0));
        r.tag          = spq_pkg::TAG_FIELD_BITS'($urandom_range(16'hFFFF, 0));
        r.priority_req = spq_pkg::PRIO_BITS'($urandom_range(1023, 0));
        r.index        = spq_pkg::POS_BITS'($urandom_range(63, 0));
        return r;
    endfunction

    function automatic void add_request(logic [spq_pkg::REQ_BITS-1:0] rt,
                                        logic [spq_pkg::TAG_FIELD_BITS-1:0] tg,
                                        logic [spq_pkg::PRIO_BITS-1:0] pr,
                                        logic [spq_pkg::POS_BITS-1:0] ix);
        spq_pkg::req_t r;
        r.req_type     = rt;
        r.tag          = tg;
        r.priority_req = pr;
        r.index        = ix;
        pending_items.push_back(r);
        case (rt)
            spq_pkg::REQ_INSERT: if (gen_count < QDEPTH) gen_count++;
            spq_pkg::REQ_POP:    if (gen_count > 0) gen_count--;
            spq_pkg::REQ_CLEAR:  gen_count = 0;
            default:    ;
        endcase
    endfunction

    function automatic logic [spq_pkg::TAG_FIELD_BITS-1:0] pick_tag(int pool_pct);
        if ($urandom_range(99, 0) < pool_pct)
            return tag_pool[$urandom_range(15, 0)];
        return spq_pkg::TAG_FIELD_BITS'($urandom_range(16'hFFFF, 0));
    endfunction

    function automatic logic [spq_pkg::PRIO_BITS-1:0] pick_priority();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return spq_pkg::PRIO_BITS'($urandom_range(12, 1));
        if (r < 90)
            return spq_pkg::PRIO_BITS'($urandom_range(999, 1));
        if (r < 95)
            return '0;
        return spq_pkg::PRIO_BITS'($urandom_range(1023, 1000));
    endfunction

    function automatic logic [spq_pkg::POS_BITS-1:0] pick_index();
        if (gen_count > 0 && $urandom_range(99, 0) < 80)
            return spq_pkg::POS_BITS'($urandom_range(gen_count - 1, 0));
        return spq_pkg::POS_BITS'($urandom_range(63, 0));
    endfunction

    function automatic logic [spq_pkg::REQ_BITS-1:0] pick_op(int w_ins, int w_pop, int w_find,
                                                             int w_read, int w_clear);
        int r;
        r = $urandom_range(99, 0);
        if (r < w_ins)
            return spq_pkg::REQ_INSERT;
        r -= w_ins;
        if (r < w_pop)
            return spq_pkg::REQ_POP;
        r -= w_pop;
        if (r < w_find)
            return spq_pkg::REQ_FIND;
        r -= w_find;
        if (r < w_read)
            return spq_pkg::REQ_READ;
        r -= w_read;
        if (r < w_clear)
            return spq_pkg::REQ_CLEAR;
        return spq_pkg::REQ_BITS'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    endfunction

    // Unused fields of each request carry random noise.
    function automatic void add_random_request(logic [spq_pkg::REQ_BITS-1:0] rt);
        spq_pkg::req_t r;
        r = random_request();
        case (rt)
            spq_pkg::REQ_INSERT:
            begin
                r.tag          = pick_tag(60);
                r.priority_req = pick_priority();
            end
            spq_pkg::REQ_FIND: r.tag   = pick_tag(70);
            spq_pkg::REQ_READ: r.index = pick_index();
            default:  ;
        endcase
        add_request(rt, r.tag, r.priority_req, r.index);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        bit idle_now;
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(serve_request(request));
                items_accepted++;
            end
            if (!start || !busy)
            begin
                idle_now = (items_accepted < QUIET_FROM || items_accepted >= QUIET_TO)
                           && ($urandom_range(99, 0) < IDLE_PCT);
                if (pending_items.size() > 0 && !idle_now)
                begin
                    start   <= 1'b1;
                    request <= pending_items.pop_front();
                end
                else
                begin
                    start   <= 1'b0;
                    request <= random_request();
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        spq_pkg::rsp_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              result.status, want.status));
                if (result.entry_tag !== want.entry_tag)
                    report_mismatch($sformatf("entry_tag got %0h expected %0h",
                                              result.entry_tag, want.entry_tag));
                if (result.entry_priority !== want.entry_priority)
                    report_mismatch($sformatf("entry_priority got %0d expected %0d",
                                              result.entry_priority, want.entry_priority));
                if (result.entry_position !== want.entry_position)
                    report_mismatch($sformatf("entry_position got %0d expected %0d",
                                              result.entry_position, want.entry_position));
                if (result.count !== want.count)
                    report_mismatch($sformatf("count got %0d expected %0d",
                                              result.count, want.count));
                if (result.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty got %0b expected %0b",
                                              result.is_empty, want.is_empty));
            end
        end
    end

    initial
    begin : run_test
        int          random_items;
        int          extra;
        int          len;
        phase_kind_t phase;
        logic [spq_pkg::REQ_BITS-1:0] op;

        for (int i = 0; i < 16; i++)
            tag_pool[i] = spq_pkg::TAG_FIELD_BITS'($urandom_range(16'hFFFF, 0));

        // Requests on an empty queue, then inserts at the priority extremes and ties.
        add_request(spq_pkg::REQ_POP, 16'h0000, 10'd1, 6'd0);
        add_request(spq_pkg::REQ_FIND, 16'h0000, 10'd1, 6'd0);
        add_request(spq_pkg::REQ_READ, 16'hFFFF, 10'd999, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'hFFFF, 10'd999, 6'd63);
        add_request(spq_pkg::REQ_INSERT, 16'h0000, 10'd1, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'h1234, 10'd999, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'hA5A5, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'h5A5A, 10'd1023, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'h1234, 10'd500, 6'd0);
        add_request(spq_pkg::REQ_FIND, 16'h1234, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_FIND, 16'hBEEF, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_READ, 16'h0000, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_READ, 16'h0000, 10'd0, 6'd5);
        add_request(spq_pkg::REQ_READ, 16'h0000, 10'd0, 6'd6);
        add_request(spq_pkg::REQ_READ, 16'h0000, 10'd0, 6'd63);
        add_request(REQ_UNUSED_LO, 16'hFFFF, 10'd1023, 6'd63);
        add_request(REQ_UNUSED_MID, 16'h0F0F, 10'd1, 6'd1);
        add_request(REQ_UNUSED_HI, 16'h0000, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_POP, 16'hFFFF, 10'd1023, 6'd63);
        add_request(spq_pkg::REQ_POP, 16'h0000, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_CLEAR, 16'hFFFF, 10'd1023, 6'd63);
        add_request(spq_pkg::REQ_POP, 16'h0000, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_READ, 16'h0000, 10'd0, 6'd0);
        add_request(spq_pkg::REQ_INSERT, 16'h8001, 10'd512, 6'd0);

        random_items = 0;
        phase        = PH_FILL;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                PH_FILL:
                begin
                    extra = $urandom_range(6, 2);
                    while (gen_count < QDEPTH || extra > 0)
                    begin
                        op = pick_op(80, 5, 7, 8, 0);
                        if (op == spq_pkg::REQ_INSERT && gen_count == QDEPTH)
                            extra--;
                        add_random_request(op);
                        random_items++;
                    end
                end
                PH_DRAIN:
                begin
                    extra = $urandom_range(4, 1);
                    while (gen_count > 0 || extra > 0)
                    begin
                        op = pick_op(10, 70, 10, 10, 0);
                        if (op == spq_pkg::REQ_POP && gen_count == 0)
                            extra--;
                        add_random_request(op);
                        random_items++;
                    end
                end
                PH_MIXED:
                begin
                    len = $urandom_range(60, 20);
                    for (int i = 0; i < len; i++)
                    begin
                        add_random_request(pick_op(38, 25, 15, 15, 3));
                        random_items++;
                    end
                end
                default:
                begin
                    len = $urandom_range(40, 15);
                    for (int i = 0; i < len; i++)
                    begin
                        add_random_request(pick_op(6, 4, 44, 44, 0));
                        random_items++;
                    end
                end
            endcase
            phase = phase_kind_t'($urandom_range(PH_QUERY, PH_FILL));
        end
        total_items = pending_items.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(items_accepted == total_items && expected_results.size() == 0))
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/spq_pkg.sv
design/spq_ram.sv
design/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
